// ----- sv/ecss_pkg.sv -----
`timescale 1ns / 1ps

package ecss_pkg;

    // Capture store geometry.
    localparam int VAR_LEN     = 32;
    localparam int NUM_VARS    = 4;
    localparam int LEN_W       = $clog2(VAR_LEN + 1);
    localparam int IDX_W       = $clog2(VAR_LEN);
    localparam int SLOT_W      = 2;
    localparam int ADDR_W      = IDX_W + SLOT_W;
    localparam int STORE_DEPTH = NUM_VARS * VAR_LEN;

    // Result queue geometry.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Characters recognised by the command parser.
    localparam logic [7:0] CH_US   = 8'h5F;  // '_'
    localparam logic [7:0] CH_QM   = 8'h3F;  // '?'
    localparam logic [7:0] CH_HU   = 8'h48;  // 'H'
    localparam logic [7:0] CH_HL   = 8'h68;  // 'h'
    localparam logic [7:0] CH_CU   = 8'h43;  // 'C'
    localparam logic [7:0] CH_CL   = 8'h63;  // 'c'
    localparam logic [7:0] CH_FL   = 8'h66;  // 'f'
    localparam logic [7:0] CH_FU   = 8'h46;  // 'F'
    localparam logic [7:0] CH_RL   = 8'h72;  // 'r'
    localparam logic [7:0] CH_BANG = 8'h21;  // '!'
    localparam logic [7:0] CH_ONE  = 8'h31;  // '1'
    localparam logic [7:0] CH_FOUR = 8'h34;  // '4'
    localparam logic [7:0] CH_SEMI = 8'h3B;  // ';'

    typedef enum logic [4:0] {
        PH_TEXT    = 5'b00001,
        PH_UNDER   = 5'b00010,
        PH_PREFIX  = 5'b00100,
        PH_INDEX   = 5'b01000,
        PH_CAPTURE = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        SQ_IDLE   = 2'b01,
        SQ_REPLAY = 2'b10
    } seq_t;

    typedef struct packed {
        logic              hen;
        logic              cen;
        phase_t            phase;
        logic [SLOT_W-1:0] slot;
        logic              err;
    } ctl_t;

    localparam ctl_t CTL_RESET = '{hen: 1'b1, cen: 1'b1, phase: PH_TEXT,
                                   slot: '0, err: 1'b0};

    typedef struct packed {
        logic       hv;
        logic [7:0] hb;
        logic       cv;
        logic [7:0] cb;
        logic       err;
        logic       last;
    } result_t;

    localparam result_t RES_ERR = '{hv: 1'b0, hb: 8'd0, cv: 1'b0, cb: 8'd0,
                                    err: 1'b1, last: 1'b0};

    // Up to two results produced directly by one input byte.
    typedef struct packed {
        logic [1:0]        n;
        result_t [1:0]     r;
    } rlist_t;

    typedef logic [NUM_VARS-1:0][LEN_W-1:0] lens_t;

    typedef struct packed {
        ctl_t              ctl_next;
        lens_t             lens_next;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rp_en;
        logic [SLOT_W-1:0] rp_slot;
        logic              rp_hv;
        logic              rp_cv;
        logic [LEN_W-1:0]  rp_len;
        rlist_t            res;
    } dec_t;

endpackage

// ----- sv/ecss_decode.sv -----
`timescale 1ns / 1ps

module ecss_decode
(
    input  ecss_pkg::ctl_t  ctl,
    input  ecss_pkg::lens_t lens_in,
    input  logic [7:0]      data_byte,
    input  logic            end_of_stream,
    output ecss_pkg::dec_t  dec
);
    import ecss_pkg::*;

    ctl_t              c;
    lens_t             lens;
    rlist_t            res;
    logic              is_digit;
    logic [SLOT_W-1:0] dslot;

    // Appends a result to the list.
    function automatic rlist_t add_res(rlist_t l, result_t x);
        rlist_t o;
        o = l;
        if (l.n == 2'd0)
        begin
            o.r[0] = x;
        end
        else
        begin
            o.r[1] = x;
        end
        o.n = l.n + 2'd1;
        return o;
    endfunction

    // A literal byte goes to every enabled channel, or nowhere.
    function automatic rlist_t add_lit(rlist_t l, logic hen, logic cen, logic [7:0] b);
        result_t x;
        rlist_t  o;
        x.hv   = hen;
        x.hb   = hen ? b : 8'd0;
        x.cv   = cen;
        x.cb   = cen ? b : 8'd0;
        x.err  = 1'b0;
        x.last = 1'b0;
        o = l;
        if (hen || cen)
        begin
            o = add_res(l, x);
        end
        return o;
    endfunction

    assign is_digit = (data_byte >= CH_ONE) && (data_byte <= CH_FOUR);
    assign dslot    = data_byte[SLOT_W-1:0] - SLOT_W'(1);

    always_comb
    begin
        c    = ctl;
        lens = lens_in;
        res  = '0;
        dec  = '0;
        dec.wr_addr = {ctl.slot, lens_in[ctl.slot][IDX_W-1:0]};
        dec.wr_data = data_byte;
        dec.rp_slot = dslot;
        dec.rp_hv   = ctl.hen & dslot[1];
        dec.rp_cv   = ctl.cen;
        dec.rp_len  = lens_in[dslot];

        if (ctl.err)
        begin
            res = add_res(res, RES_ERR);
        end
        else
        begin
            case (ctl.phase)
                PH_TEXT:
                begin
                    if (data_byte == CH_US)
                    begin
                        c.phase = PH_UNDER;
                    end
                    else
                    begin
                        res = add_lit(res, c.hen, c.cen, data_byte);
                    end
                end
                PH_UNDER:
                begin
                    if (data_byte == CH_QM)
                    begin
                        c.phase = PH_PREFIX;
                    end
                    else
                    begin
                        // A lone underscore is ordinary text; a second one
                        // may still open a prefix.
                        res = add_lit(res, c.hen, c.cen, CH_US);
                        if (data_byte != CH_US)
                        begin
                            res     = add_lit(res, c.hen, c.cen, data_byte);
                            c.phase = PH_TEXT;
                        end
                    end
                end
                PH_PREFIX:
                begin
                    c.phase = PH_TEXT;
                    case (data_byte)
                        CH_HU: c.hen = 1'b1;
                        CH_HL: c.hen = 1'b0;
                        CH_CU: c.cen = 1'b1;
                        CH_CL: c.cen = 1'b0;
                        CH_FU: c.hen = 1'b1;
                        CH_FL:
                        begin
                            res   = add_res(res, '{hv: 1'b1, hb: CH_SEMI, cv: 1'b0,
                                                   cb: 8'd0, err: 1'b0, last: 1'b0});
                            c.hen = 1'b0;
                            c.cen = 1'b1;
                        end
                        CH_RL: c.phase = PH_INDEX;
                        CH_BANG:
                        begin
                            res = add_lit(res, c.hen, c.cen, CH_US);
                            res = add_lit(res, c.hen, c.cen, CH_QM);
                        end
                        default:
                        begin
                            if (is_digit && (dec.rp_hv || dec.rp_cv) &&
                                (lens_in[dslot] != '0))
                            begin
                                dec.rp_en = 1'b1;
                            end
                        end
                    endcase
                end
                PH_INDEX:
                begin
                    if (is_digit)
                    begin
                        c.slot      = dslot;
                        lens[dslot] = '0;
                        c.phase     = PH_CAPTURE;
                    end
                    else
                    begin
                        c.phase = PH_TEXT;
                        c.err   = 1'b1;
                        res     = add_res(res, RES_ERR);
                    end
                end
                PH_CAPTURE:
                begin
                    if (data_byte == CH_SEMI)
                    begin
                        c.phase = PH_TEXT;
                    end
                    else if (lens_in[ctl.slot] < LEN_W'(VAR_LEN))
                    begin
                        dec.wr_en      = 1'b1;
                        lens[ctl.slot] = lens_in[ctl.slot] + LEN_W'(1);
                    end
                end
                default:
                begin
                    c.phase = PH_TEXT;
                end
            endcase

            // Flush whatever the stream end leaves pending.
            if (end_of_stream && !c.err)
            begin
                case (c.phase)
                    PH_UNDER:
                    begin
                        res = add_lit(res, c.hen, c.cen, CH_US);
                    end
                    PH_PREFIX:
                    begin
                        res = add_lit(res, c.hen, c.cen, CH_US);
                        res = add_lit(res, c.hen, c.cen, CH_QM);
                    end
                    PH_INDEX, PH_CAPTURE:
                    begin
                        c.err = 1'b1;
                        res   = add_res(res, RES_ERR);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (end_of_stream)
        begin
            c    = CTL_RESET;
            lens = '0;
        end

        if (res.n == 2'd1)
        begin
            res.r[0].last = 1'b1;
        end
        else if (res.n == 2'd2)
        begin
            res.r[1].last = 1'b1;
        end

        dec.ctl_next  = c;
        dec.lens_next = lens;
        dec.res       = res;
    end

endmodule

// ----- sv/ecss_outq.sv -----
`timescale 1ns / 1ps

module ecss_outq
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ecss_pkg::rlist_t              push,
    input  logic                          pop,
    output ecss_pkg::result_t             head,
    output logic [ecss_pkg::Q_CNT_W-1:0]  count
);
    import ecss_pkg::*;

    result_t              q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;

    assign wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push.n);
    assign rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
    assign count_next  = count_reg + Q_CNT_W'(push.n) - Q_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            q_mem[wr_ptr_reg] <= push.r[0];
        end
        if (push.n == 2'd2)
        begin
            q_mem[wr_ptr_reg + Q_PTR_W'(1)] <= push.r[1];
        end
    end

    assign head  = q_mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

// ----- sv/escape_command_stream_splitter.sv -----
`timescale 1ns / 1ps
// A result is written to the result queue when its byte is accepted and is presented from
// the queue head. A replayed variable passes through the sequencer, the store read register
// and the queue, one store read per cycle while the queue has room. Bytes with two results
// are paced by the output, one result per cycle while out_stall is low, once the queue fills.
// A replay reads through the single read port of the store, and input is held off until it ends.
// Reset is asynchronous and active low; it clears flags, parse state, lengths, sequencer and queue pointers.

module escape_command_stream_splitter
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       header_valid,
    output logic [7:0] header_byte,
    output logic       code_valid,
    output logic [7:0] code_byte,
    output logic       error_flag,
    output logic       run_end
);
    import ecss_pkg::*;

    // Channel enables, the parse phase, the capture slot and the sticky error
    // live in ctl_reg. The four lengths are small and need a reset value, so
    // they sit in flip-flops; the captured bytes live in a synchronous store
    // with a registered read. Store contents are never cleared, as no
    // entry beyond a variable's length is ever read.
    ctl_t                ctl_reg;
    lens_t               lens_reg;
    dec_t                dec;
    logic                accept;

    logic [7:0]          store_mem [STORE_DEPTH];
    logic [7:0]          rd_data_reg;
    logic                rd_en;
    logic                rd_last;
    logic [ADDR_W-1:0]   rd_addr;

    // Replay sequencer. It walks one variable, one store read per cycle while
    // the queue has room, and each read turns into one result transaction on the following cycle.
    seq_t                seq_reg;
    seq_t                seq_next;
    logic [SLOT_W-1:0]   rp_slot_reg;
    logic [SLOT_W-1:0]   rp_slot_next;
    logic                rp_hv_reg;
    logic                rp_hv_next;
    logic                rp_cv_reg;
    logic                rp_cv_next;
    logic [LEN_W-1:0]    rp_len_reg;
    logic [LEN_W-1:0]    rp_len_next;
    logic [LEN_W-1:0]    rp_idx_reg;
    logic [LEN_W-1:0]    rp_idx_next;
    logic                pend_reg;
    logic                pend_last_reg;

    rlist_t              push;
    result_t             head;
    logic [Q_CNT_W-1:0]  q_count;
    logic                pop;

    ecss_decode u_decode
    (
        .ctl           (ctl_reg),
        .lens_in       (lens_reg),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .dec           (dec)
    );

    // Input is held off during a replay, while its last read is still in
    // flight, and whenever the queue could not take two more results.
    assign in_stall = (seq_reg != SQ_IDLE) || pend_reg ||
                      (q_count > Q_CNT_W'(Q_DEPTH - 2));
    assign accept   = in_valid && !in_stall;

    // A read is issued only when the queue is sure to have room for its
    // result, counting the read already in flight.
    assign rd_en   = (seq_reg == SQ_REPLAY) &&
                     ((q_count + Q_CNT_W'(pend_reg)) < Q_CNT_W'(Q_DEPTH));
    assign rd_last = (rp_idx_reg == (rp_len_reg - LEN_W'(1)));
    assign rd_addr = {rp_slot_reg, rp_idx_reg[IDX_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (accept && dec.wr_en)
        begin
            store_mem[dec.wr_addr] <= dec.wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_comb
    begin
        seq_next     = seq_reg;
        rp_slot_next = rp_slot_reg;
        rp_hv_next   = rp_hv_reg;
        rp_cv_next   = rp_cv_reg;
        rp_len_next  = rp_len_reg;
        rp_idx_next  = rp_idx_reg;
        case (seq_reg)
            SQ_IDLE:
            begin
                if (accept && dec.rp_en)
                begin
                    seq_next     = SQ_REPLAY;
                    rp_slot_next = dec.rp_slot;
                    rp_hv_next   = dec.rp_hv;
                    rp_cv_next   = dec.rp_cv;
                    rp_len_next  = dec.rp_len;
                    rp_idx_next  = '0;
                end
            end
            SQ_REPLAY:
            begin
                if (rd_en)
                begin
                    rp_idx_next = rp_idx_reg + LEN_W'(1);
                    if (rd_last)
                    begin
                        seq_next = SQ_IDLE;
                    end
                end
            end
            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= CTL_RESET;
            lens_reg      <= '0;
            seq_reg       <= SQ_IDLE;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ctl_reg  <= dec.ctl_next;
                lens_reg <= dec.lens_next;
            end
            seq_reg       <= seq_next;
            pend_reg      <= rd_en;
            pend_last_reg <= rd_last;
        end
    end

    always_ff @(posedge clk)
    begin
        rp_slot_reg <= rp_slot_next;
        rp_hv_reg   <= rp_hv_next;
        rp_cv_reg   <= rp_cv_next;
        rp_len_reg  <= rp_len_next;
        rp_idx_reg  <= rp_idx_next;
    end

    // Results from an accepted byte and from the replay never meet in one
    // cycle, because input is stalled for the whole replay.
    always_comb
    begin
        push = '0;
        if (accept)
        begin
            push = dec.res;
        end
        else if (pend_reg)
        begin
            push.n         = 2'd1;
            push.r[0].hv   = rp_hv_reg;
            push.r[0].hb   = rp_hv_reg ? rd_data_reg : 8'd0;
            push.r[0].cv   = rp_cv_reg;
            push.r[0].cb   = rp_cv_reg ? rd_data_reg : 8'd0;
            push.r[0].err  = 1'b0;
            push.r[0].last = pend_last_reg;
        end
    end

    assign pop = out_valid && !out_stall;

    ecss_outq u_outq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .count (q_count)
    );

    assign out_valid    = (q_count != '0);
    assign header_valid = head.hv;
    assign header_byte  = head.hb;
    assign code_valid   = head.cv;
    assign code_byte    = head.cb;
    assign error_flag   = head.err;
    assign run_end      = head.last;

`ifndef SYNTHESIS
    // The queue never takes more results than it can hold.
    a_queue_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        ((Q_CNT_W + 1)'(q_count) + (Q_CNT_W + 1)'(push.n)) <= (Q_CNT_W + 1)'(Q_DEPTH))
        else $error("result queue overflow");

    // The replay walk stays inside the captured part of the variable.
    a_replay_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SQ_REPLAY) |-> (rp_idx_reg < rp_len_reg))
        else $error("replay index beyond variable length");

    // Captured lengths never exceed the space of one variable.
    a_len_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        (lens_reg[0] <= LEN_W'(VAR_LEN)) && (lens_reg[1] <= LEN_W'(VAR_LEN)) &&
        (lens_reg[2] <= LEN_W'(VAR_LEN)) && (lens_reg[3] <= LEN_W'(VAR_LEN)))
        else $error("variable length out of range");

    // An error result carries no byte on either channel.
    a_error_clean : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_flag) |-> (!header_valid && !code_valid))
        else $error("error result carries data");
`endif

endmodule

// ----- test/escape_split_checker.sv -----
`timescale 1ns / 1ps

module escape_split_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       header_valid,
    input  logic [7:0] header_byte,
    input  logic       code_valid,
    input  logic [7:0] code_byte,
    input  logic       error_flag,
    input  logic       run_end,
    output int         fail_count,
    output int         pending_count
);
    import ecss_pkg::*;

    localparam int MAX_PER_ITEM = 32;

    // Mirror of the splitter's routing state.
    logic              hdr_on;
    logic              code_on;
    logic              err_seen;
    phase_t            phase;
    logic [SLOT_W-1:0] cap_slot;
    logic [7:0]        var_text [NUM_VARS][VAR_LEN];
    int unsigned       var_len [NUM_VARS];

    // Routed bytes still to be seen on the output, oldest first.
    result_t routed_q[$];
    result_t step_out[$];
    int      fails = 0;

    function automatic void restart_stream();
        hdr_on   = 1'b1;
        code_on  = 1'b1;
        err_seen = 1'b0;
        phase    = PH_TEXT;
        cap_slot = '0;
        foreach (var_len[i])
            var_len[i] = 0;
    endfunction

    function automatic void emit_result(logic hv, logic [7:0] hb, logic cv, logic [7:0] cb,
                                        logic er);
        result_t r;
        if (step_out.size() >= MAX_PER_ITEM)
            return;
        r.hv   = hv;
        r.hb   = hv ? hb : 8'd0;
        r.cv   = cv;
        r.cb   = cv ? cb : 8'd0;
        r.err  = er;
        r.last = 1'b0;
        step_out.insert(step_out.size(), r);
    endfunction

    function automatic void pass_text(logic [7:0] b);
        if (hdr_on || code_on)
            emit_result(hdr_on, b, code_on, b, 1'b0);
    endfunction

    function automatic void flag_error();
        err_seen = 1'b1;
        emit_result(1'b0, 8'd0, 1'b0, 8'd0, 1'b1);
    endfunction

    function automatic void run_command(logic [7:0] x);
        logic [SLOT_W-1:0] s;
        logic              hv;
        case (x)
            CH_HU: hdr_on = 1'b1;
            CH_HL: hdr_on = 1'b0;
            CH_CU: code_on = 1'b1;
            CH_CL: code_on = 1'b0;
            CH_FL:
            begin
                emit_result(1'b1, CH_SEMI, 1'b0, 8'd0, 1'b0);
                hdr_on  = 1'b0;
                code_on = 1'b1;
            end
            CH_FU: hdr_on = 1'b1;
            CH_RL: phase = PH_INDEX;
            CH_BANG:
            begin
                pass_text(CH_US);
                pass_text(CH_QM);
            end
            default:
            begin
                // Only the upper two variables are replayed to the header as well.
                if (x >= CH_ONE && x <= CH_FOUR)
                begin
                    s  = SLOT_W'(x - CH_ONE);
                    hv = hdr_on && (s >= 2);
                    if (hv || code_on)
                        for (int q = 0; q < var_len[s]; q++)
                            emit_result(hv, var_text[s][q], code_on, var_text[s][q], 1'b0);
                end
            end
        endcase
    endfunction

    function automatic void route_byte(logic [7:0] b, logic eos);
        result_t r;
        step_out.delete();
        if (err_seen)
            emit_result(1'b0, 8'd0, 1'b0, 8'd0, 1'b1);
        else
        begin
            case (phase)
                PH_TEXT:
                begin
                    if (b == CH_US)
                        phase = PH_UNDER;
                    else
                        pass_text(b);
                end
                PH_UNDER:
                begin
                    if (b == CH_QM)
                        phase = PH_PREFIX;
                    else
                    begin
                        pass_text(CH_US);
                        if (b != CH_US)
                        begin
                            pass_text(b);
                            phase = PH_TEXT;
                        end
                    end
                end
                PH_PREFIX:
                begin
                    phase = PH_TEXT;
                    run_command(b);
                end
                PH_INDEX:
                begin
                    if (b < CH_ONE || b > CH_FOUR)
                    begin
                        phase = PH_TEXT;
                        flag_error();
                    end
                    else
                    begin
                        cap_slot          = SLOT_W'(b - CH_ONE);
                        var_len[cap_slot] = 0;
                        phase             = PH_CAPTURE;
                    end
                end
                default:
                begin
                    if (b == CH_SEMI)
                        phase = PH_TEXT;
                    else if (var_len[cap_slot] < VAR_LEN)
                    begin
                        var_text[cap_slot][var_len[cap_slot]] = b;
                        var_len[cap_slot]++;
                    end
                end
            endcase
            if (eos && !err_seen)
            begin
                case (phase)
                    PH_UNDER: pass_text(CH_US);
                    PH_PREFIX:
                    begin
                        pass_text(CH_US);
                        pass_text(CH_QM);
                    end
                    PH_INDEX, PH_CAPTURE: flag_error();
                    default: ;
                endcase
            end
        end
        if (eos)
            restart_stream();
        foreach (step_out[i])
        begin
            r      = step_out[i];
            r.last = (i == step_out.size() - 1);
            routed_q.insert(routed_q.size(), r);
        end
    endfunction

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endfunction

    function automatic void check_result();
        result_t want;
        if (routed_q.size() == 0)
        begin
            $error("result with nothing expected: header %0d/%0d code %0d/%0d error %0d end %0d",
                   header_valid, header_byte, code_valid, code_byte, error_flag, run_end);
            fails++;
            return;
        end
        want = routed_q.pop_front();
        compare_field("header_valid", want.hv, header_valid);
        compare_field("header_byte", want.hb, header_byte);
        compare_field("code_valid", want.cv, code_valid);
        compare_field("code_byte", want.cb, code_byte);
        compare_field("error_flag", want.err, error_flag);
        compare_field("run_end", want.last, run_end);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_stream();
            routed_q.delete();
            pending_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                route_byte(data_byte, end_of_stream);
            if (out_valid && !out_stall)
                check_result();
            fail_count    <= fails;
            pending_count <= routed_q.size();
        end
    end

endmodule

// ----- test/tb_escape_command_stream_splitter.sv -----
`timescale 1ns / 1ps

module tb_escape_command_stream_splitter;
    import ecss_pkg::*;

    // One input transaction: a byte and whether it closes the stream.
    typedef struct packed {
        logic [7:0] b;
        logic       eos;
    } in_item_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte     = 8'd0;
    logic       end_of_stream = 1'b0;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    logic       header_valid;
    logic [7:0] header_byte;
    logic       code_valid;
    logic [7:0] code_byte;
    logic       error_flag;
    logic       run_end;

    int         fail_count;
    int         pending_count;

    // Set for the closing stretch of the run, where neither side idles.
    logic       calm          = 1'b0;

    // Every byte to be sent, in order, built before reset is released.
    in_item_t   stream_plan[$];

    always #5 clk = ~clk;

    escape_command_stream_splitter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .header_valid  (header_valid),
        .header_byte   (header_byte),
        .code_valid    (code_valid),
        .code_byte     (code_byte),
        .error_flag    (error_flag),
        .run_end       (run_end)
    );

    escape_split_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .header_valid  (header_valid),
        .header_byte   (header_byte),
        .code_valid    (code_valid),
        .code_byte     (code_byte),
        .error_flag    (error_flag),
        .run_end       (run_end),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    function automatic void queue_byte(logic [7:0] b);
        in_item_t it;
        it.b   = b;
        it.eos = 1'b0;
        stream_plan.insert(stream_plan.size(), it);
    endfunction

    function automatic void queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endfunction

    // Flags the most recently queued byte as the last of its stream.
    function automatic void mark_end();
        stream_plan[stream_plan.size() - 1].eos = 1'b1;
    endfunction

    // A capture command with random content. The content never holds the
    // terminator, so its length is exactly what was asked for. Now and then
    // the capture is longer than a variable can hold, so that the excess
    // bytes are seen to be dropped.
    function automatic void queue_capture(logic terminated);
        int         len;
        logic [7:0] b;
        queue_text("_?");
        queue_byte(CH_RL);
        queue_byte(CH_ONE + 8'($urandom_range(0, 3)));
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(VAR_LEN - 2, VAR_LEN + 8)
                                          : $urandom_range(0, 6);
        repeat (len)
        begin
            do
                b = 8'($urandom);
            while (b == CH_SEMI);
            queue_byte(b);
        end
        if (terminated)
            queue_byte(CH_SEMI);
    endfunction

    // A command prefix followed by a channel switch, a replay, the literal
    // escape or, occasionally, an arbitrary byte.
    function automatic void queue_command();
        int pick;
        pick = $urandom_range(0, 13);
        queue_text("_?");
        case (pick)
            0:  queue_byte(CH_HU);
            1:  queue_byte(CH_HL);
            2:  queue_byte(CH_CU);
            3:  queue_byte(CH_CL);
            4:  queue_byte(CH_FL);
            5:  queue_byte(CH_FU);
            6:  queue_byte(CH_BANG);
            13: queue_byte(8'($urandom));
            default: queue_byte(CH_ONE + 8'($urandom_range(0, 3)));
        endcase
    endfunction

    // Most of a random stream is well formed: text, commands and captures
    // whose variables are later replayed. A small share is noise: lone
    // underscores, bad capture indexes, and streams that stop in the middle
    // of a prefix or a capture.
    function automatic void add_random_stream();
        int         pick;
        logic [7:0] b;
        repeat ($urandom_range(1, 12))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                queue_byte(8'($urandom));
            else if (pick < 70)
                queue_command();
            else if (pick < 88)
                queue_capture(1'b1);
            else if (pick < 96)
                queue_byte(CH_US);
            else
            begin
                queue_text("_?");
                queue_byte(CH_RL);
                do
                    b = 8'($urandom);
                while (b >= CH_ONE && b <= CH_FOUR);
                queue_byte(b);
            end
        end
        pick = $urandom_range(0, 19);
        if (pick == 0)
            queue_byte(CH_US);
        else if (pick == 1)
            queue_text("_?");
        else if (pick == 2)
            queue_capture(1'b0);
        else
            queue_byte(8'($urandom));
        mark_end();
    endfunction

    function automatic void build_plan();
        // The extremes of the byte range pass as plain text to both channels.
        queue_byte(8'h00);
        queue_byte(8'hFF);
        // An underscore that does not start a command is passed on as text.
        queue_text("_a");
        // Capture into the fourth variable, then replay it to both channels.
        queue_text("_?r4Q;");
        queue_text("_?4");
        // Header off, then the code switch that also emits the terminator.
        queue_text("_?h_?f");
        // A stream that ends on a pending prefix flushes it as literal bytes.
        queue_text("_?");
        mark_end();
        // A bad capture index latches the error until the stream ends.
        queue_text("_?r9x");
        mark_end();
        // A stream that ends while a capture index is awaited.
        queue_text("_?r");
        mark_end();
        while (stream_plan.size() < 200)
            add_random_stream();
    endfunction

    // The receiver stalls in random bursts, sometimes followed by
    // a longer free stretch, and never once the closing stretch has begun.
    int stall_left = 0;
    int free_left  = 0;

    always @(posedge clk)
    begin
        if (calm || !rst_n)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
            if (stall_left == 0 && $urandom_range(0, 3) == 0)
                free_left = $urandom_range(20, 60);
        end
        else if (free_left > 0)
        begin
            free_left--;
            out_stall <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 14) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Source side: one transaction per planned byte, held until accepted.
    initial
    begin
        in_item_t it;
        int       gap_pct;
        logic     quiet;
        gap_pct = 20;
        build_plan();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int k = 0; k < stream_plan.size(); k++)
        begin
            it    = stream_plan[k];
            quiet = (k >= stream_plan.size() - 40);
            calm <= quiet;
            // The idling rate changes from time to time, so that some
            // stretches carry no gaps at all.
            if (k % 25 == 0)
                gap_pct = $urandom_range(0, 1) ? 0 : 35;
            if (!quiet && $urandom_range(0, 99) < gap_pct)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            in_valid      <= 1'b1;
            data_byte     <= it.b;
            end_of_stream <= it.eos;
            do
                @(posedge clk);
            while (in_stall);
        end
        in_valid      <= 1'b0;
        end_of_stream <= 1'b0;
        // The checker's count of outstanding results is registered and lags behind.
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        // Any stray result must have shown up well within this window.
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("PASS escape_command_stream_splitter");
        else
            $display("FAIL escape_command_stream_splitter");
        $finish;
    end

    // Guard against a block that stops moving transactions.
    initial
    begin
        #5_000_000;
        $display("FAIL escape_command_stream_splitter");
        $finish;
    end

endmodule
